// ----- rtl/vctf_pkg.sv -----
// ----------------------------------------------------------------------------
// vctf_pkg
// Types and codes shared by the vertex component to float conversion block.
// ----------------------------------------------------------------------------
package vctf_pkg;

	localparam int unsigned RawW = 32;
	localparam int unsigned LzW = 5;
	localparam int unsigned KindW = 3;
	localparam int unsigned CfgIndexW = 1;
	localparam int unsigned CfgDataW = 3;

	localparam logic [CfgIndexW-1:0] CFG_KIND = 1'd0;
	localparam logic [CfgIndexW-1:0] CFG_NORM = 1'd1;

	typedef enum logic [KindW-1:0] {
		KIND_SBYTE  = 3'd0,
		KIND_UBYTE  = 3'd1,
		KIND_SSHORT = 3'd2,
		KIND_USHORT = 3'd3,
		KIND_UINT   = 3'd4,
		KIND_FLOAT  = 3'd5
	} kind_t;

	localparam logic [31:0] FLOAT_NEG_ONE = 32'hBF80_0000;
	localparam logic [31:0] FLOAT_ZERO = 32'h0000_0000;

	typedef struct packed {
		logic              sign;
		logic              zero;
		logic [RawW-1:0]   mag;
		logic [LzW-1:0]    lz;
	} dec_t;

endpackage

// ----- rtl/vctf_decode.sv -----
// ----------------------------------------------------------------------------
// vctf_decode
// Extracts sign and magnitude of the component and counts its leading zeros.
// ----------------------------------------------------------------------------
module vctf_decode (
	input  logic [31:0]          raw,
	input  logic [2:0]           kind,
	output vctf_pkg::dec_t       dec
);
	import vctf_pkg::*;

	logic [RawW-1:0] mag;
	logic            sign;
	logic [LzW-1:0]  lz;

	always_comb begin
		sign = 1'b0;
		mag = raw;
		case (kind)
			KIND_SBYTE: begin
				sign = raw[7];
				mag = raw[7] ? {24'd0, 8'(-raw[7:0])} : {24'd0, raw[7:0]};
				if (raw[7:0] == 8'h80) begin
					mag = 32'd128;
				end
			end
			KIND_UBYTE: mag = {24'd0, raw[7:0]};
			KIND_SSHORT: begin
				sign = raw[15];
				mag = raw[15] ? {16'd0, 16'(-raw[15:0])} : {16'd0, raw[15:0]};
				if (raw[15:0] == 16'h8000) begin
					mag = 32'd32768;
				end
			end
			KIND_USHORT: mag = {16'd0, raw[15:0]};
			default: mag = raw;
		endcase
	end

	always_comb begin
		lz = '0;
		for (int i = 0; i < RawW; i++) begin
			if (mag[i]) begin
				lz = LzW'(RawW - 1 - i);
			end
		end
	end

	assign dec.sign = sign;
	assign dec.zero = (mag == '0);
	assign dec.mag = mag;
	assign dec.lz = lz;

endmodule

// ----- rtl/vctf_round.sv -----
// ----------------------------------------------------------------------------
// vctf_round
// Normalizes the magnitude, scales by the type maximum when asked, and
// rounds to nearest even into a single-precision pattern.
// ----------------------------------------------------------------------------
module vctf_round (
	input  vctf_pkg::dec_t dec,
	input  logic [31:0]    raw,
	input  logic [2:0]     kind,
	input  logic           norm,
	output logic [31:0]    result
);
	import vctf_pkg::*;

	logic [63:0] win;
	logic [63:0] win_sh;
	logic [31:0] plain_sh;
	logic [4:0]  k;
	logic [3:0]  sh;
	logic        scale;
	logic        clamp;
	logic [23:0] m24;
	logic        rnd;
	logic        sticky;
	logic        up;
	logic [24:0] sum;
	logic [8:0]  expo;
	logic [7:0]  expo_f;
	logic [22:0] frac;
	logic [31:0] packed_f;

	assign scale = norm && (kind == KIND_SBYTE || kind == KIND_UBYTE ||
		kind == KIND_SSHORT || kind == KIND_USHORT);

	always_comb begin
		k = 5'd16;
		win = {4{dec.mag[15:0]}};
		case (kind)
			KIND_SBYTE: begin
				k = 5'd7;
				win = {{9{dec.mag[6:0]}}, 1'b0};
			end
			KIND_UBYTE: begin
				k = 5'd8;
				win = {8{dec.mag[7:0]}};
			end
			KIND_SSHORT: begin
				k = 5'd15;
				win = {{4{dec.mag[14:0]}}, 4'd0};
			end
			default: begin
				k = 5'd16;
				win = {4{dec.mag[15:0]}};
			end
		endcase
	end

	assign sh = 4'(dec.lz - (5'd0 - k));
	assign win_sh = win << sh;
	assign plain_sh = dec.mag << dec.lz;
	assign clamp = dec.sign &&
		((kind == KIND_SBYTE && dec.mag == 32'd128) ||
		(kind == KIND_SSHORT && dec.mag == 32'd32768));

	always_comb begin
		if (scale) begin
			m24 = win_sh[63:40];
			rnd = win_sh[39];
			sticky = 1'b1;
			expo = 9'd158 - {4'd0, dec.lz} - {4'd0, k};
		end else begin
			m24 = plain_sh[31:8];
			rnd = plain_sh[7];
			sticky = |plain_sh[6:0];
			expo = 9'd158 - {4'd0, dec.lz};
		end
		up = rnd && (sticky || m24[0]);
		sum = {1'b0, m24} + {24'd0, up};
		expo_f = sum[24] ? 8'(expo + 9'd1) : expo[7:0];
		frac = sum[24] ? sum[23:1] : sum[22:0];
		packed_f = {dec.sign, expo_f, frac};
	end

	always_comb begin
		case (kind)
			KIND_FLOAT: result = raw;
			KIND_SBYTE, KIND_UBYTE, KIND_SSHORT, KIND_USHORT, KIND_UINT: begin
				if (dec.zero) begin
					result = FLOAT_ZERO;
				end else if (scale && clamp) begin
					result = FLOAT_NEG_ONE;
				end else begin
					result = packed_f;
				end
			end
			default: result = FLOAT_ZERO;
		endcase
	end

endmodule

// ----- rtl/vertex_component_to_float_core.sv -----
// ----------------------------------------------------------------------------
// vertex_component_to_float_core
// Converts raw vertex attribute components into single-precision patterns.
// ----------------------------------------------------------------------------
// One component is taken per cycle while in_stall is low, and its result
// passes through the input register, a decode register after the stage
// that finds the leading one, and the output register after the rounding
// stage before it is presented. The whole pipeline holds while a result
// waits under out_stall.
module vertex_component_to_float_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [vctf_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [vctf_pkg::CfgDataW-1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] raw_component,
	input  logic        is_last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] float_bits,
	output logic        is_last_out
);
	import vctf_pkg::*;

	logic [2:0]  kind_q;
	logic        norm_q;
	logic        advance;
	logic        vld_s1, vld_s2;
	logic [31:0] raw_s1, raw_s2;
	logic        last_s1, last_s2;
	dec_t        dec_c, dec_s2;
	logic [31:0] result_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_SBYTE;
			norm_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_KIND) begin
				kind_q <= cfg_data;
			end
			if (cfg_index == CFG_NORM) begin
				norm_q <= cfg_data[0];
			end
		end
	end

	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			raw_s1 <= raw_component;
			last_s1 <= is_last_in;
			raw_s2 <= raw_s1;
			last_s2 <= last_s1;
			dec_s2 <= dec_c;
			float_bits <= result_c;
			is_last_out <= last_s2;
		end
	end

	vctf_decode u_decode (
		.raw  (raw_s1),
		.kind (kind_q),
		.dec  (dec_c)
	);

	vctf_round u_round (
		.dec    (dec_s2),
		.raw    (raw_s2),
		.kind   (kind_q),
		.norm   (norm_q),
		.result (result_c)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && advance) |=> out_valid)
		else $error("result lost between stages");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance) |=> (vld_s1 == $past(vld_s1) && vld_s2 == $past(vld_s2)))
		else $error("pipeline moved while held");

endmodule
